// ----- sv/pbh_pkg.sv -----
// Package for the partition bucket hash: Murmur3-32 constants, widths,
// register address and the control and status types of the modulo unit.
// No dependencies; every other file of the block imports it.
package pbh_pkg;

  // Default number of key bytes carried by one chunk.
  localparam int BYTES_PER_CHUNK_DEF = 8;

  // Murmur3-32 block and finalizer constants.
  localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2  = 32'h1b873593;
  localparam logic [31:0] MM_ADD = 32'he6546b64;
  localparam logic [31:0] MM_F1  = 32'h85ebca6b;
  localparam logic [31:0] MM_F2  = 32'hc2b2ae35;
  localparam logic [31:0] SEED   = 32'h0;

  // Width of the masked hash, of the bucket count and of the bucket index.
  localparam int DIV_W = 31;

  // Configuration register map.
  localparam int          ADDR_W            = 2;
  localparam logic [ADDR_W-1:0] ADDR_BUCKET_COUNT = 2'd0;
  localparam logic [DIV_W-1:0]  BUCKET_COUNT_RST  = 31'd16;

  // Control of the iterative modulo unit.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } pbh_div_ctrl_t;

  // Status of the iterative modulo unit.
  typedef struct packed {
    logic busy;
    logic done;
  } pbh_div_stat_t;

endpackage

// ----- sv/partition_bucket_hash.sv -----
// Top level of the partition bucket hash: Murmur3-32 sequencer with one
// shared multiplier, APB configuration and the valid/stall channels.
// Depends on pbh_pkg and pbh_div.
//
// The block hashes a key, sent as chunks of little-endian bytes, with
// Murmur3-32 at seed zero and maps the hash to a bucket by taking
// (hash AND 0x7fffffff) mod bucket_count. Each chunk is one input
// transaction; only the transaction marked last_chunk yields a result
// transaction. One 32x32 multiplier is shared by the scramble and
// finalizer multiplies, so each four-byte block passes through a
// byte-gather state, the C1 and C2 multiply states and the hash update
// state. A tail of one to three bytes is scrambled in place of a block.
// The last chunk then passes through the finalizer states and the
// bit-serial modulo unit before the output register loads. in_stall is
// high while a chunk is in work and while a finished result waits for
// the output register to free up; a result held in the output register
// does not block a new chunk. bucket_count sits at byte address 0 and
// resets to 16.
module partition_bucket_hash
  import pbh_pkg::*;
#(
  parameter int BYTES_PER_CHUNK = BYTES_PER_CHUNK_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // Chunk input channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [8*BYTES_PER_CHUNK-1:0] key_bytes,
  input  logic [3:0]                   byte_count,
  input  logic                         last_chunk,
  // Result output channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [31:0]                  hash_value,
  output logic [DIV_W-1:0]             bucket_index,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int DATA_W = 8 * BYTES_PER_CHUNK;
  localparam int REM_W  = $clog2(BYTES_PER_CHUNK + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SCR1, S_SCR2, S_MIX, S_TXOR, S_FIN1, S_FIN2, S_FIN3, S_DIV
  } state_t;

  state_t            state;
  logic [DIV_W-1:0]  bucket_count;
  logic [31:0]       running_hash;
  logic [31:0]       key_length;
  logic [31:0]       tail;
  logic [1:0]        tcount;
  logic              fin;
  logic              last;
  logic [DATA_W-1:0] data;
  logic [REM_W-1:0]  remaining;
  logic [31:0]       prod;
  logic [31:0]       hash_fin;

  logic [REM_W-1:0]  count_eff;
  logic [2:0]        need;
  logic [3:0]        rem4;
  logic [2:0]        take;
  logic [31:0]       lane;
  logic [31:0]       tail_fill;
  logic [2:0]        fill_sum;
  logic [REM_W-1:0]  remaining_next;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [31:0]       mul_p;
  logic [31:0]       fin_x;
  logic [31:0]       mix_x;
  logic [31:0]       mix_r;
  logic [31:0]       mix_h;
  logic [31:0]       hash_out;
  logic              cfg_write;
  logic              deliver;

  pbh_div_ctrl_t     div_ctrl;
  pbh_div_stat_t     div_stat;
  logic [DIV_W-1:0]  div_result;

  // Configuration port: a single register, always ready.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr == ADDR_BUCKET_COUNT) ? {1'b0, bucket_count} : '0;

  assign in_stall = (state != S_IDLE);

  // A non-final chunk always carries a full chunk; an oversized count saturates.
  always_comb begin
    if (!last_chunk || (byte_count > 4'(BYTES_PER_CHUNK))) begin
      count_eff = REM_W'(BYTES_PER_CHUNK);
    end else begin
      count_eff = REM_W'(byte_count);
    end
  end

  // Byte gather: move as many bytes as fit into the four-byte block.
  always_comb begin
    need = 3'd4 - {1'b0, tcount};
    rem4 = 4'(remaining);
    take = ({1'b0, need} < rem4) ? need : rem4[2:0];
    for (int i = 0; i < 4; i++) begin
      lane[i*8 +: 8] = (3'(i) < take) ? data[i*8 +: 8] : 8'h00;
    end
    tail_fill      = tail | (lane << {tcount, 3'b000});
    fill_sum       = {1'b0, tcount} + take;
    remaining_next = remaining - REM_W'(take);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    fin_x = running_hash ^ key_length;
    case (state)
      S_SCR1: begin
        mul_a = tail;
        mul_b = MM_C1;
      end
      S_SCR2: begin
        mul_a = {prod[16:0], prod[31:17]};
        mul_b = MM_C2;
      end
      S_FIN1: begin
        mul_a = fin_x ^ (fin_x >> 16);
        mul_b = MM_F1;
      end
      S_FIN2: begin
        mul_a = prod ^ (prod >> 13);
        mul_b = MM_F2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = 32'(mul_a * mul_b);
  end

  // Hash update for a scrambled block, and the last finalizer step.
  always_comb begin
    mix_x    = running_hash ^ prod;
    mix_r    = {mix_x[18:0], mix_x[31:19]};
    mix_h    = {mix_r[29:0], 2'b00} + mix_r + MM_ADD;
    hash_out = prod ^ (prod >> 16);
  end

  // Modulo unit is started as the finalized hash is formed.
  assign div_ctrl = '{start:    (state == S_FIN3),
                      dividend: hash_out[DIV_W-1:0],
                      divisor:  bucket_count};

  pbh_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .stat      (div_stat),
    .remainder (div_result)
  );

  // The result is delivered once the modulo is done and the output is free.
  assign deliver = div_stat.done && !div_stat.busy && (!out_valid || !out_stall);

  // Sequencer, key state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      bucket_count <= BUCKET_COUNT_RST;
      running_hash <= SEED;
      key_length   <= '0;
      tail         <= '0;
      tcount       <= '0;
      fin          <= 1'b0;
    end else begin
      if (cfg_write) begin
        bucket_count <= pwdata[DIV_W-1:0];
      end
      // The output register empties when taken, unless a new result refills it.
      if (out_valid && !out_stall && !((state == S_DIV) && deliver)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            data       <= key_bytes;
            remaining  <= count_eff;
            last       <= last_chunk;
            key_length <= key_length + 32'(count_eff);
            state      <= S_LOAD;
          end
        end
        S_LOAD: begin
          tail      <= tail_fill;
          data      <= data >> {take, 3'b000};
          remaining <= remaining_next;
          if (fill_sum == 3'd4) begin
            tcount <= '0;
            state  <= S_SCR1;
          end else begin
            tcount <= fill_sum[1:0];
            if (remaining_next != '0) begin
              state <= S_LOAD;
            end else if (!last) begin
              state <= S_IDLE;
            end else if (fill_sum != 3'd0) begin
              fin   <= 1'b1;
              state <= S_SCR1;
            end else begin
              state <= S_FIN1;
            end
          end
        end
        S_SCR1: begin
          prod  <= mul_p;
          state <= S_SCR2;
        end
        S_SCR2: begin
          prod  <= mul_p;
          state <= fin ? S_TXOR : S_MIX;
        end
        S_MIX: begin
          running_hash <= mix_h;
          tail         <= '0;
          if (remaining != '0) begin
            state <= S_LOAD;
          end else if (last) begin
            state <= S_FIN1;
          end else begin
            state <= S_IDLE;
          end
        end
        S_TXOR: begin
          running_hash <= running_hash ^ prod;
          fin          <= 1'b0;
          state        <= S_FIN1;
        end
        S_FIN1: begin
          prod  <= mul_p;
          state <= S_FIN2;
        end
        S_FIN2: begin
          prod  <= mul_p;
          state <= S_FIN3;
        end
        S_FIN3: begin
          hash_fin <= hash_out;
          state    <= S_DIV;
        end
        S_DIV: begin
          if (deliver) begin
            out_valid    <= 1'b1;
            hash_value   <= hash_fin;
            bucket_index <= div_result;
            running_hash <= SEED;
            key_length   <= '0;
            tail         <= '0;
            tcount       <= '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/pbh_div.sv -----
// Iterative restoring modulo unit for the partition bucket hash.
// Computes dividend mod divisor one quotient bit per cycle. Uses pbh_pkg.
module pbh_div
  import pbh_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  pbh_div_ctrl_t    ctrl,
  output pbh_div_stat_t    stat,
  output logic [DIV_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dq;
  logic [DIV_W-1:0] divisor_q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             fits;

  // One restoring step: shift in the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {rem, dq[DIV_W-1]};
    diff  = trial - {1'b0, divisor_q};
    fits  = (trial >= {1'b0, divisor_q});
  end

  // Sequencer for the shift and subtract loop.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (ctrl.start) begin
      busy      <= 1'b1;
      done      <= 1'b0;
      cnt       <= CNT_W'(DIV_W - 1);
      rem       <= '0;
      dq        <= ctrl.dividend;
      divisor_q <= ctrl.divisor;
    end else if (busy) begin
      rem <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      dq  <= {dq[DIV_W-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // A zero divisor gives a zero result.
  assign remainder = (divisor_q == '0) ? '0 : rem;
  assign stat      = '{busy: busy, done: done};

endmodule

// ----- sv/pbh_checker.sv -----
// Port-level checks for the partition bucket hash, attached by bind.
// Depends on pbh_pkg and the ports of partition_bucket_hash.
module pbh_checker
  import pbh_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [31:0]      hash_value,
  input logic [DIV_W-1:0] bucket_index,
  input logic [31:0]      prdata
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hash_value) && $stable(bucket_index))
    else $error("stalled result changed");

  // The block stalls its input in the cycle after each accepted chunk.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accept");

  // A new result only appears at the end of work on a chunk.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while the block was idle");

  // The bucket index stays below the bucket count read back on the port.
  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (prdata[DIV_W-1:0] != '0) |-> bucket_index < prdata[DIV_W-1:0])
    else $error("bucket index out of range");

endmodule

bind partition_bucket_hash pbh_checker u_pbh_checker (.*);
